FILE: rtl/emac_pkg.sv
// types, constants and helper functions of the echo motion alarm controller
package emac_pkg;

  // field widths
  localparam int unsigned DIST_W = 16;
  localparam int unsigned ACT_W  = 2;
  localparam int unsigned CODE_W = 2;

  // arming sample set
  localparam int unsigned ARM_SAMPLES = 4;
  localparam int unsigned IDX_W       = $clog2(ARM_SAMPLES);
  localparam int unsigned CNT_W       = $clog2(ARM_SAMPLES + 1);
  localparam int unsigned SUM_W       = DIST_W + $clog2(ARM_SAMPLES);

  // tolerance after reset
  localparam logic [DIST_W-1:0] TOL_RESET = DIST_W'(100);

  // item actions
  typedef enum logic [ACT_W-1:0] {
    ACT_ARM   = 2'd0,
    ACT_RESET = 2'd1,
    ACT_RISE  = 2'd2,
    ACT_FALL  = 2'd3
  } action_e;

  // alarm state codes as seen on the result item
  localparam logic [CODE_W-1:0] CODE_IDLE   = 2'd0;
  localparam logic [CODE_W-1:0] CODE_ARMING = 2'd1;
  localparam logic [CODE_W-1:0] CODE_ARMED  = 2'd2;
  localparam logic [CODE_W-1:0] CODE_FIRED  = 2'd3;

  // controller modes, one-hot
  typedef enum logic [3:0] {
    MODE_IDLE   = 4'b0001,
    MODE_ARMING = 4'b0010,
    MODE_ARMED  = 4'b0100,
    MODE_FIRED  = 4'b1000
  } mode_e;

  // mode to result code
  function automatic logic [CODE_W-1:0] mode_code(mode_e m);
    logic [CODE_W-1:0] c;
    unique case (m)
      MODE_IDLE:   c = CODE_IDLE;
      MODE_ARMING: c = CODE_ARMING;
      MODE_ARMED:  c = CODE_ARMED;
      MODE_FIRED:  c = CODE_FIRED;
      default:     c = CODE_IDLE;
    endcase
    return c;
  endfunction

  // true when |mean - d| < tol
  function automatic logic within_tol(logic [DIST_W-1:0] mean, logic [DIST_W-1:0] d,
                                      logic [DIST_W-1:0] tol);
    logic [DIST_W-1:0] diff;
    diff = (mean >= d) ? (mean - d) : (d - mean);
    return diff < tol;
  endfunction

endpackage

FILE: rtl/echo_motion_alarm_controller_unit.sv
// echo motion alarm controller: input register, state update and result register
//
// Motion alarm driven by echo edge timestamps. Each item (arm press, reset press,
// echo rising or falling edge) yields exactly one result item carrying the mode
// after the item, the latest echo width, the reference mean and the fired and
// arming-failed flags. The block takes one item per cycle while the result
// side is not stalled; an accepted item is held in the input register and then
// in the result register, and the state update plus the four-sample tolerance
// check run combinationally between those two registers. The tolerance register is
// written through the cfg channel, which is always ready; write it only while no
// item is in flight.
module echo_motion_alarm_controller_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // config write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [emac_pkg::DIST_W-1:0]    cfg_data_i,
  // input item channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [emac_pkg::ACT_W-1:0]     action_i,
  input  logic [emac_pkg::DIST_W-1:0]    capture_time_i,
  // result item channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [emac_pkg::CODE_W-1:0]    alarm_state_o,
  output logic [emac_pkg::DIST_W-1:0]    measured_distance_o,
  output logic [emac_pkg::DIST_W-1:0]    reference_level_o,
  output logic                           fired_now_o,
  output logic                           arming_failed_o
);
  import emac_pkg::*;

  // handshake and pipeline control
  logic                  s1_valid_q;
  logic [ACT_W-1:0]      s1_action_q;
  logic [DIST_W-1:0]     s1_time_q;
  logic                  out_valid_q;
  logic                  out_free;
  logic                  s1_fire;
  logic                  in_fire;

  // block state
  logic [DIST_W-1:0]     tol_q;
  mode_e                 mode_q, mode_d;
  logic [DIST_W-1:0]     start_q, start_d;
  logic [DIST_W-1:0]     samples_q [ARM_SAMPLES];
  logic [CNT_W-1:0]      count_q, count_d;
  logic [SUM_W-1:0]      sum_q, sum_d;
  logic [DIST_W-1:0]     mean_q, mean_d;
  logic [DIST_W-1:0]     dist_q, dist_d;
  logic                  sample_we;

  // result register
  logic [CODE_W-1:0]     res_state_q;
  logic [DIST_W-1:0]     res_dist_q;
  logic [DIST_W-1:0]     res_mean_q;
  logic                  res_fired_q, res_fired_d;
  logic                  res_failed_q, res_failed_d;

  // arming check helpers
  logic [DIST_W-1:0]     new_dist;
  logic [SUM_W-1:0]      sum_new;
  logic [DIST_W-1:0]     mean_new;
  logic [DIST_W-1:0]     chk_sample [ARM_SAMPLES];
  logic                  all_ok;
  action_e               act;

  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign s1_fire     = s1_valid_q && out_free;
  assign in_stall_o  = s1_valid_q && !out_free;
  assign in_fire     = in_valid_i && !in_stall_o;

  // tolerance register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      tol_q <= cfg_data_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_action_q <= action_i;
      s1_time_q   <= capture_time_i;
    end
  end

  // distance, running sum and mean of the full sample set
  assign act      = action_e'(s1_action_q);
  assign new_dist = s1_time_q - start_q;
  assign sum_new  = sum_q + SUM_W'(new_dist);
  assign mean_new = DIST_W'(sum_new / ARM_SAMPLES);

  // samples to check: stored ones plus the one arriving now
  always_comb begin
    for (int i = 0; i < ARM_SAMPLES; i++) begin
      chk_sample[i] = (count_q[IDX_W-1:0] == IDX_W'(i)) ? new_dist : samples_q[i];
    end
  end

  always_comb begin
    all_ok = 1'b1;
    for (int i = 0; i < ARM_SAMPLES; i++) begin
      if (!within_tol(mean_new, chk_sample[i], tol_q)) begin
        all_ok = 1'b0;
      end
    end
  end

  // next state
  always_comb begin
    mode_d       = mode_q;
    start_d      = start_q;
    count_d      = count_q;
    sum_d        = sum_q;
    mean_d       = mean_q;
    dist_d       = dist_q;
    sample_we    = 1'b0;
    res_fired_d  = 1'b0;
    res_failed_d = 1'b0;
    unique case (act)
      ACT_ARM: begin
        if (mode_q == MODE_IDLE) begin
          mode_d  = MODE_ARMING;
          count_d = '0;
          sum_d   = '0;
        end
      end
      ACT_RESET: begin
        if (mode_q == MODE_ARMED || mode_q == MODE_FIRED) begin
          mode_d = MODE_IDLE;
        end
      end
      ACT_RISE: begin
        start_d = s1_time_q;
      end
      ACT_FALL: begin
        dist_d = new_dist;
        if (mode_q == MODE_ARMING) begin
          sample_we = 1'b1;
          if (count_q == CNT_W'(ARM_SAMPLES - 1)) begin
            // last sample: settle arming
            mean_d  = mean_new;
            count_d = '0;
            sum_d   = '0;
            if (all_ok) begin
              mode_d = MODE_ARMED;
            end else begin
              mode_d       = MODE_IDLE;
              res_failed_d = 1'b1;
            end
          end else begin
            count_d = count_q + CNT_W'(1);
            sum_d   = sum_new;
          end
        end else if (mode_q == MODE_ARMED) begin
          if (!within_tol(mean_q, new_dist, tol_q)) begin
            mode_d      = MODE_FIRED;
            res_fired_d = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      start_q <= '0;
      count_q <= '0;
      sum_q   <= '0;
      mean_q  <= '0;
      dist_q  <= '0;
    end else if (s1_fire) begin
      mode_q  <= mode_d;
      start_q <= start_d;
      count_q <= count_d;
      sum_q   <= sum_d;
      mean_q  <= mean_d;
      dist_q  <= dist_d;
    end
  end

  // arming sample store
  always_ff @(posedge clk_i) begin
    if (s1_fire && sample_we) begin
      samples_q[count_q[IDX_W-1:0]] <= new_dist;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      res_state_q  <= mode_code(mode_d);
      res_dist_q   <= dist_d;
      res_mean_q   <= mean_d;
      res_fired_q  <= res_fired_d;
      res_failed_q <= res_failed_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign alarm_state_o       = res_state_q;
  assign measured_distance_o = res_dist_q;
  assign reference_level_o   = res_mean_q;
  assign fired_now_o         = res_fired_q;
  assign arming_failed_o     = res_failed_q;

  // checks
  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(fired_now_o && arming_failed_o))
    else $error("fired and arming-failed flagged on one item");

  a_fired_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && fired_now_o) |-> (alarm_state_o == CODE_FIRED))
    else $error("fired item without fired state");

  a_failed_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && arming_failed_o) |-> (alarm_state_o == CODE_IDLE))
    else $error("failed arming item without idle state");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i && s1_valid_q))
    else $error("input stalled with room downstream");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q < CNT_W'(ARM_SAMPLES))
    else $error("sample count out of range");

endmodule
